### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("i2cbs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("i2cbs check failed");

`endif

### rtl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Types and constants shared by the I2C master bit sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbs_pkg;

  // Request codes on the input tuser field; a tick also marks the idle command
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4,
    REQ_SACK  = 3'd5,
    REQ_RACK  = 3'd6
  } req_e;

  // Position inside a three-phase bit slot of write and read
  localparam logic [1:0] KIND_DATA = 2'd0;  // drive SDA (write) / raise SCL (read)
  localparam logic [1:0] KIND_MID  = 2'd1;  // raise SCL (write) / sample (read)
  localparam logic [1:0] KIND_LOW  = 2'd2;  // drop SCL

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One classified item as it travels from front to back
  typedef struct packed {
    req_e       kind;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       rejected;
    logic       ack_in;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

  // Number of phases in each command
  function automatic logic [4:0] seq_len(input req_e cmd);
    logic [4:0] len;
    case (cmd)
      REQ_START: len = 5'd4;
      REQ_STOP:  len = 5'd3;
      REQ_WRITE: len = 5'd24;
      REQ_READ:  len = 5'd25;
      REQ_SACK:  len = 5'd3;
      REQ_RACK:  len = 5'd4;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/i2cbs_front.sv
// ----------------------------------------------------------------------------
// i2cbs_front
// Accepts input transfers, decodes the request code and unpacks the payload
// into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_front import i2cbs_pkg::*; (
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // tx_byte[7:0], ack_bit[8], sda_in[9]
  input  wire logic [2:0]  s_axis_tuser,  // req_type[2:0]
  input  wire logic        q_full_i,
  output logic             push_o,
  output item_t            push_item_o
);

  // Unused code seven behaves as a tick
  req_e kind;
  always_comb begin
    case (s_axis_tuser)
      REQ_START: kind = REQ_START;
      REQ_STOP:  kind = REQ_STOP;
      REQ_WRITE: kind = REQ_WRITE;
      REQ_READ:  kind = REQ_READ;
      REQ_SACK:  kind = REQ_SACK;
      REQ_RACK:  kind = REQ_RACK;
      default:   kind = REQ_TICK;
    endcase
  end

  assign s_axis_tready       = !q_full_i;
  assign push_o              = s_axis_tvalid && !q_full_i;
  assign push_item_o.kind    = kind;
  assign push_item_o.tx_byte = s_axis_tdata[7:0];
  assign push_item_o.ack_bit = s_axis_tdata[8];
  assign push_item_o.sda_in  = s_axis_tdata[9];

endmodule

`default_nettype wire

### rtl/i2cbs_queue.sv
// ----------------------------------------------------------------------------
// i2cbs_queue
// Small FIFO between front and back; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_queue import i2cbs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       valid_o,
  output logic       full_o
);

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/i2cbs_back.sv
// ----------------------------------------------------------------------------
// i2cbs_back
// Runs the phase sequence of the current command, counts hold ticks and
// registers one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbs_back import i2cbs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire item_t       item_i,
  input  wire logic        item_valid_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output res_t             res_o
);

  logic [15:0] ptk_q;
  req_e        cmd_q, cmd_d;
  logic [4:0]  phase_q, phase_d;
  logic [15:0] tcnt_q, tcnt_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  tx_q, tx_d, rx_q, rx_d;
  logic        ack_q, ack_d, sack_q, sack_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        ovld_q, ovld_d;
  res_t        res_q, res_d;

  logic        step, busy, done, rej;
  logic [16:0] tinc;
  logic [15:0] hold;
  logic [4:0]  ph_nxt;

  assign busy  = (cmd_q != REQ_TICK);
  assign step  = item_valid_i && (!ovld_q || m_axis_tready);
  assign pop_o = step;
  assign tinc  = {1'b0, tcnt_q} + 17'd1;
  assign hold  = (ptk_q == '0) ? 16'd1 : ptk_q;
  assign ph_nxt = phase_q + 5'd1;

  // Sequencer: command start or rejection, hold counting, phase entry
  always_comb begin
    cmd_d   = cmd_q;
    phase_d = phase_q;
    tcnt_d  = tcnt_q;
    kind_d  = kind_q;
    bit_d   = bit_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    sack_d  = sack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (step) begin
      if (item_i.kind != REQ_TICK) begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          cmd_d   = item_i.kind;
          phase_d = '0;
          tcnt_d  = '0;
          kind_d  = KIND_DATA;
          bit_d   = '0;
          case (item_i.kind)
            REQ_START: sda_d = 1'b1;
            REQ_STOP:  sda_d = 1'b0;
            REQ_WRITE: begin
              tx_d  = item_i.tx_byte;
              sda_d = item_i.tx_byte[7];
            end
            REQ_READ: begin
              rx_d  = '0;
              sda_d = 1'b1;
            end
            REQ_SACK: begin
              sack_d = item_i.ack_bit;
              sda_d  = item_i.ack_bit;
            end
            REQ_RACK: sda_d = 1'b1;
            default: ;
          endcase
        end
      end else if (busy) begin
        if (tinc >= {1'b0, hold}) begin
          tcnt_d = '0;
          if (ph_nxt >= seq_len(cmd_q)) begin
            cmd_d   = REQ_TICK;
            phase_d = '0;
            done    = 1'b1;
          end else begin
            phase_d = ph_nxt;
            // bit slot position; read has a lead-in phase before its first slot
            if (cmd_q == REQ_READ && phase_q == '0) begin
              kind_d = KIND_DATA;
              bit_d  = '0;
            end else if (kind_q == KIND_LOW) begin
              kind_d = KIND_DATA;
              bit_d  = bit_q + 3'd1;
            end else begin
              kind_d = kind_q + 2'd1;
            end
            case (cmd_q)
              REQ_START: begin
                if (ph_nxt == 5'd1) scl_d = 1'b1;
                else if (ph_nxt == 5'd2) sda_d = 1'b0;
                else scl_d = 1'b0;
              end
              REQ_STOP: begin
                if (ph_nxt == 5'd1) scl_d = 1'b1;
                else sda_d = 1'b1;
              end
              REQ_WRITE: begin
                if (kind_d == KIND_DATA) sda_d = tx_q[~bit_d];
                else if (kind_d == KIND_MID) scl_d = 1'b1;
                else scl_d = 1'b0;
              end
              REQ_READ: begin
                if (kind_d == KIND_DATA) scl_d = 1'b1;
                else if (kind_d == KIND_MID) rx_d[~bit_d] = rx_q[~bit_d] | item_i.sda_in;
                else scl_d = 1'b0;
              end
              REQ_SACK: begin
                if (ph_nxt == 5'd1) scl_d = 1'b1;
                else scl_d = 1'b0;
              end
              REQ_RACK: begin
                if (ph_nxt == 5'd1) scl_d = 1'b1;
                else if (ph_nxt == 5'd2) ack_d = item_i.sda_in;
                else scl_d = 1'b0;
              end
              default: ;
            endcase
          end
        end else begin
          tcnt_d = tinc[15:0];
        end
      end
    end
  end

  // Result word and output slot
  always_comb begin
    res_d.scl_out  = scl_d;
    res_d.sda_out  = sda_d;
    res_d.busy_res = (cmd_d != REQ_TICK);
    res_d.done_res = done;
    res_d.rx_byte  = rx_d;
    res_d.ack_in   = ack_d;
    res_d.rejected = rej;
    if (step) begin
      ovld_d = 1'b1;
    end else if (m_axis_tready) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptk_q   <= PHASE_TICKS_RST;
      cmd_q   <= REQ_TICK;
      phase_q <= '0;
      tcnt_q  <= '0;
      kind_q  <= KIND_DATA;
      bit_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      ack_q   <= 1'b0;
      sack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ovld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ptk_q <= cfg_wdata_i;
      end
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      tcnt_q  <= tcnt_d;
      kind_q  <= kind_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
      sack_q  <= sack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ovld_q  <= ovld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign res_o         = res_q;

endmodule

`default_nettype wire

### rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Open-drain I2C master line sequencer: start, stop, byte write/read and
// ack send/receive expanded into timed SCL/SDA phases.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser carries the request code (tick, start, stop,
//   write, read, send ack, receive ack); tdata carries the byte to send, the
//   ack level to drive and the sampled SDA level. Ticks stand for time.
//   Output stream (m_axis): one result per input transfer with the SCL/SDA
//   drive levels, busy, done, received byte, sampled ack and rejected flag.
//   cfg_we_i/cfg_wdata_i set the number of ticks each phase is held.
//   A result is offered after its input transfer is written into the queue and
//   then taken by the sequencer step into the result register; the block takes
//   one item per cycle while the output is not stalled.
//   A two-entry queue separates decode from the sequencer, so an output stall
//   fills the queue first; s_axis_tready drops only when the queue is full.
//   Reset releases both lines, idles the sequencer and loads a hold of ten
//   ticks; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer import i2cbs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // phase_ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,    // tx_byte[7:0], ack_bit[8], sda_in[9]
  input  wire logic [2:0]  s_axis_tuser,    // req_type[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
  // ack_in[12], rejected[13]
  output logic [15:0]      m_axis_tdata
);

  logic  push, pop, q_full, q_valid;
  item_t push_item, q_item;
  res_t  res;

  i2cbs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  i2cbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .item_o      (q_item),
    .valid_o     (q_valid),
    .full_o      (q_full)
  );

  i2cbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_i        (q_item),
    .item_valid_i  (q_valid),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

`default_nettype wire

### rtl/i2cbs_checker.sv
// ----------------------------------------------------------------------------
// i2cbs_checker
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cbs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // A finished command leaves the sequencer idle
  `CHK_IMPL(a_done_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[3], !m_axis_tdata[2])

  // A command is only rejected while another one is running
  `CHK_IMPL(a_rej_busy, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[2])

  // A stalled result stays offered
  `CHK_NEXT(a_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // A stalled result keeps its payload
  `CHK_NEXT(a_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (.*);

`default_nettype wire
